FILE: rtl/core/i2c_master_bit_engine_defines.svh
// assertion macros used by the i2c master bit engine sequencer
// expects clk and rst_n in the module that uses them
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define I2CM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/i2cm_pkg.sv
// types and constants for the i2c master bit engine
// no dependencies
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;
    localparam int          CMD_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_RECV_ACK = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       ack_to_send;
        logic [7:0] bus_sda_bits;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sample_phase;
        logic [7:0] read_data;
        logic       ack_seen;
        logic       last;
    } out_item_t;

    // classified command handed from the front to the sequencer
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       ack;
        logic [7:0] seen;
    } cmd_t;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_PHASE = 2'd1,
        SEQ_HOLD  = 2'd2
    } seq_state_t;

endpackage

FILE: rtl/core/i2cm_front.sv
// front end: accepts input items, drops unused codes, queues commands
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_front #(
    parameter int DEPTH = i2cm_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  i2cm_pkg::in_item_t in_item,
    output logic               cmd_valid,
    output i2cm_pkg::cmd_t     cmd,
    input  logic               cmd_take
);
    import i2cm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            cmd_mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            is_cmd;
    logic            wr_en;
    logic            rd_en;
    cmd_t            new_cmd;

    // codes above receive ack are swallowed without a queue entry
    assign is_cmd = (in_item.operation <= 3'(OP_RECV_ACK));
    assign full   = (count_reg == CW'(DEPTH));
    assign wr_en  = push && !full && is_cmd;
    assign rd_en  = cmd_take && (count_reg != '0);

    always_comb
    begin
        new_cmd.op   = op_t'(in_item.operation);
        new_cmd.data = in_item.data_byte;
        new_cmd.ack  = in_item.ack_to_send;
        new_cmd.seen = in_item.bus_sda_bits;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmd_mem[rd_ptr_reg];

endmodule

FILE: rtl/core/i2cm_out_q.sv
// two-entry result queue between the sequencer and the result ports
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_out_q (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  i2cm_pkg::out_item_t wr_data,
    output logic                room,
    output logic                empty,
    input  logic                pop,
    output i2cm_pkg::out_item_t out_item
);
    import i2cm_pkg::*;

    out_item_t   q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        push_ok;
    logic        pop_ok;

    assign room    = (count_reg != 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign push_ok = wr_en && room;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign out_item = q_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/i2cm_seq.sv
// back end: steps each command through its bus phases and times them
// depends on i2cm_pkg and i2c_master_bit_engine_defines.svh
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                cmd_valid,
    input  i2cm_pkg::cmd_t      cmd,
    output logic                cmd_take,
    input  logic                out_room,
    output logic                out_push,
    output i2cm_pkg::out_item_t out_data
);
    import i2cm_pkg::*;
    `include "i2c_master_bit_engine_defines.svh"

    typedef struct packed {
        logic set_scl;
        logic set_sda;
        logic level;
        logic sample;
        logic bit_end;
        logic last;
    } phase_t;

    seq_state_t  state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [15:0] ticks_reg;
    logic [15:0] hold_reg, hold_next;
    logic [1:0]  sub_reg, sub_next;
    logic [2:0]  idx_reg, idx_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        last_reg, last_next;
    logic [15:0] hold_load;
    phase_t      ph;
    logic        emit;

    // phase decode for the current command, sub step and bit index
    always_comb
    begin
        ph = '0;
        unique case (cmd_reg.op)
            OP_START:
            begin
                unique case (sub_reg)
                    2'd0:    begin ph.set_sda = 1'b1; ph.level = 1'b1; end
                    2'd1:    begin ph.set_scl = 1'b1; ph.level = 1'b1; end
                    2'd2:    begin ph.set_sda = 1'b1; ph.level = 1'b0; end
                    default: begin ph.set_scl = 1'b1; ph.level = 1'b0; ph.last = 1'b1; end
                endcase
            end
            OP_STOP:
            begin
                unique case (sub_reg)
                    2'd0:    begin ph.set_sda = 1'b1; ph.level = 1'b0; end
                    2'd1:    begin ph.set_scl = 1'b1; ph.level = 1'b1; end
                    default: begin ph.set_sda = 1'b1; ph.level = 1'b1; ph.last = 1'b1; end
                endcase
            end
            OP_WRITE, OP_SEND_ACK:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        ph.set_sda = 1'b1;
                        ph.level   = (cmd_reg.op == OP_WRITE) ?
                                     cmd_reg.data[3'd7 - idx_reg] : cmd_reg.ack;
                    end
                    2'd1:    begin ph.set_scl = 1'b1; ph.level = 1'b1; end
                    default:
                    begin
                        ph.set_scl = 1'b1;
                        ph.level   = 1'b0;
                        ph.bit_end = 1'b1;
                        ph.last    = (cmd_reg.op == OP_SEND_ACK) || (idx_reg == 3'd7);
                    end
                endcase
            end
            OP_READ, OP_RECV_ACK:
            begin
                unique case (sub_reg)
                    2'd0:    begin ph.set_sda = 1'b1; ph.level = 1'b1; end
                    2'd1:    begin ph.set_scl = 1'b1; ph.level = 1'b1; end
                    2'd2:    ph.sample = 1'b1;
                    default:
                    begin
                        ph.set_scl = 1'b1;
                        ph.level   = 1'b0;
                        ph.bit_end = 1'b1;
                        ph.last    = (cmd_reg.op == OP_RECV_ACK) || (idx_reg == 3'd7);
                    end
                endcase
            end
            default: ph = '0;
        endcase
    end

    // hold timer load: phase_ticks minus one, a setting of zero counts as one
    assign hold_load = (ticks_reg == 16'd0) ? 16'd0 : ticks_reg - 16'd1;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        hold_next  = hold_reg;
        sub_next   = sub_reg;
        idx_next   = idx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        last_next  = last_reg;
        cmd_take   = 1'b0;
        emit       = 1'b0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cmd_next   = cmd;
                    sub_next   = 2'd0;
                    idx_next   = 3'd0;
                    state_next = SEQ_PHASE;
                end
            end
            SEQ_PHASE:
            begin
                if (out_room)
                begin
                    emit      = 1'b1;
                    last_next = ph.last;
                    if (ph.set_scl)
                    begin
                        scl_next = ph.level;
                    end
                    if (ph.set_sda)
                    begin
                        sda_next = ph.level;
                    end
                    if (ph.last)
                    begin
                        sub_next = 2'd0;
                        idx_next = 3'd0;
                    end
                    else if (ph.bit_end)
                    begin
                        sub_next = 2'd0;
                        idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                    hold_next = hold_load;
                    if (hold_load != 16'd0)
                    begin
                        state_next = SEQ_HOLD;
                    end
                    else
                    begin
                        state_next = ph.last ? SEQ_IDLE : SEQ_PHASE;
                    end
                end
            end
            SEQ_HOLD:
            begin
                if (hold_reg <= 16'd1)
                begin
                    state_next = last_reg ? SEQ_IDLE : SEQ_PHASE;
                end
                else
                begin
                    hold_next = hold_reg - 16'd1;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        out_push              = emit;
        out_data.scl_level    = scl_next;
        out_data.sda_level    = sda_next;
        out_data.sample_phase = ph.sample;
        out_data.read_data    = (cmd_reg.op == OP_READ && ph.last) ? cmd_reg.seen : 8'd0;
        out_data.ack_seen     = (cmd_reg.op == OP_RECV_ACK && ph.last) ? cmd_reg.seen[7] : 1'b0;
        out_data.last         = ph.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            ticks_reg <= PHASE_TICKS_RESET;
            hold_reg  <= 16'd0;
            sub_reg   <= 2'd0;
            idx_reg   <= 3'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
            sub_reg   <= sub_next;
            idx_reg   <= idx_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            last_reg  <= last_next;
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    `I2CM_ASSERT(a_emit_has_room, emit |-> out_room, "phase emitted into a full result queue")
    `I2CM_ASSERT(a_start_ends_low, (emit && cmd_reg.op == OP_START && ph.last) |=> (!scl_reg && !sda_reg), "start did not leave both lines low")
    `I2CM_ASSERT(a_single_bit_idx, (state_reg != SEQ_IDLE && (cmd_reg.op == OP_START || cmd_reg.op == OP_STOP || cmd_reg.op == OP_SEND_ACK || cmd_reg.op == OP_RECV_ACK)) |-> (idx_reg == 3'd0), "bit index moved in a one-bit command")
    `I2CM_NEVER(n_take_while_busy, cmd_take && state_reg != SEQ_IDLE, "command taken while sequencer busy")

endmodule

FILE: rtl/core/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: front queue, sequencer, result queue
// depends on i2cm_pkg, i2cm_front, i2cm_seq, i2cm_out_q
`timescale 1ns / 1ps

// Each command yields one result per bus phase, and the hold timer in the
// sequencer times every phase from phase_ticks, zero counting as one: start
// 4 phases, stop 3, write byte 24, read byte 32, send ack 3, receive ack 4.
// After the last phase of a command the sequencer returns to idle, where it
// picks up the next command. A full result queue stretches the current phase
// until a pop makes room. Commands are queued in front (CMD_DEPTH entries),
// so push is taken every cycle until that queue fills; codes 6 and 7 are
// accepted and dropped with no result. Results wait in a two-entry queue and
// pop may stall freely. SCL and SDA levels start released.

module i2c_master_bit_engine #(
    parameter int CMD_DEPTH = i2cm_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  i2cm_pkg::in_item_t  in_item,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output logic                empty,
    input  logic                pop,
    output i2cm_pkg::out_item_t out_item
);
    import i2cm_pkg::*;

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_take;
    logic      out_room;
    logic      out_push;
    out_item_t out_data;

    i2cm_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_room  (out_room),
        .out_push  (out_push),
        .out_data  (out_data)
    );

    i2cm_out_q u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (out_push),
        .wr_data  (out_data),
        .room     (out_room),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

FILE: tb/tb.sv
// testbench for the i2c master bit engine: drives bus commands, predicts every phase
// depends on i2cm_pkg and i2c_master_bit_engine
`timescale 1ns / 1ps

module tb;
    import i2cm_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_CMDS = 500;
    localparam longint LIMIT_NS = 64'd25_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;

    // predicted bus state
    logic        bus_scl = 1'b1;
    logic        bus_sda = 1'b1;
    logic [7:0]  held_byte = '0;
    logic [15:0] ticks_now = PHASE_TICKS_RESET;

    out_item_t   phase_q[$];
    int          errors = 0;
    int          phases_checked = 0;
    int          cmds_sent = 0;
    int          settings_used = 1;
    logic        no_idle = 1'b0;
    int          hold_requests = 0;
    int          holds_done = 0;
    int          hold_left = 0;

    i2c_master_bit_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic add_phase(input logic smp, input logic [7:0] rd, input logic ack,
                             input logic fin);
        out_item_t ph;
        ph.scl_level    = bus_scl;
        ph.sda_level    = bus_sda;
        ph.sample_phase = smp;
        ph.read_data    = rd;
        ph.ack_seen     = ack;
        ph.last         = fin;
        phase_q.push_back(ph);
    endtask

    task automatic predict_phases(input in_item_t cmd);
        int i;
        case (cmd.operation)
            OP_START:
            begin
                bus_sda = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_sda = 1'b0; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b0; add_phase(1'b0, 8'h00, 1'b0, 1'b1);
            end
            OP_STOP:
            begin
                bus_sda = 1'b0; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_sda = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b1);
            end
            OP_WRITE:
            begin
                for (i = 7; i >= 0; i--)
                begin
                    bus_sda = cmd.data_byte[i]; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                    bus_scl = 1'b1;             add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                    bus_scl = 1'b0;             add_phase(1'b0, 8'h00, 1'b0, i == 0);
                end
                held_byte = cmd.data_byte;
            end
            OP_READ:
            begin
                held_byte = 8'h00;
                for (i = 0; i < 8; i++)
                begin
                    bus_sda = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                    bus_scl = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                    held_byte = {held_byte[6:0], cmd.bus_sda_bits[7 - i]};
                    add_phase(1'b1, 8'h00, 1'b0, 1'b0);
                    bus_scl = 1'b0;
                    add_phase(1'b0, (i == 7) ? held_byte : 8'h00, 1'b0, i == 7);
                end
            end
            OP_SEND_ACK:
            begin
                bus_sda = cmd.ack_to_send; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b1;            add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b0;            add_phase(1'b0, 8'h00, 1'b0, 1'b1);
            end
            OP_RECV_ACK:
            begin
                bus_sda = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b1; add_phase(1'b0, 8'h00, 1'b0, 1'b0);
                add_phase(1'b1, 8'h00, 1'b0, 1'b0);
                bus_scl = 1'b0; add_phase(1'b0, 8'h00, cmd.bus_sda_bits[7], 1'b1);
            end
            default:
            begin
                // unused codes are dropped without a phase
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // receiver side: random pop, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            pop <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end
        else if (no_idle)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= 11);
    end

    // each result transfer is checked against the oldest predicted phase
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (phase_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected phase, expected none actual %0h", $time, out_item);
            end
            else
            begin
                want = phase_q.pop_front();
                phases_checked++;
                check_field("scl_level", 8'(want.scl_level), 8'(out_item.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(out_item.sda_level));
                check_field("sample_phase", 8'(want.sample_phase),
                            8'(out_item.sample_phase));
                check_field("read_data", want.read_data, out_item.read_data);
                check_field("ack_seen", 8'(want.ack_seen), 8'(out_item.ack_seen));
                check_field("last", 8'(want.last), 8'(out_item.last));
            end
        end
    end

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] data, input logic ack,
                            input logic [7:0] seen);
        in_item_t cmd;
        cmd.operation    = op;
        cmd.data_byte    = data;
        cmd.ack_to_send  = ack;
        cmd.bus_sda_bits = seen;
        if (!no_idle)
            while ($urandom_range(99) < 11)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push <= 1'b1;
        in_item <= cmd;
        do
            @(posedge clk);
        while (full);
        predict_phases(cmd);
        if (op <= OP_RECV_ACK)
            cmds_sent++;
    endtask

    // one command with random data, ack and sampled bus levels
    task automatic send_rand_fields(input logic [2:0] op);
        send_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // let every predicted phase arrive, then give the last phase hold time to run out
    task automatic wait_idle();
        push <= 1'b0;
        while (phase_q.size() != 0)
            @(posedge clk);
        repeat (((ticks_now == 16'd0) ? 1 : int'(ticks_now)) + 40) @(posedge clk);
    endtask

    task automatic set_ticks(input logic [15:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ticks_now = v;
        settings_used++;
    endtask

    task automatic test_reset_ticks();
        send_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_RECV_ACK, 8'h00, 1'b0, 8'h80);
        send_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
    endtask

    task automatic test_directed();
        set_ticks(16'd1);
        send_cmd(OP_START, 8'hFF, 1'b1, 8'hFF);
        send_cmd(OP_WRITE, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_WRITE, 8'hFF, 1'b1, 8'hFF);
        send_cmd(OP_WRITE, 8'hA5, 1'b0, 8'h5A);
        send_cmd(OP_RECV_ACK, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_RECV_ACK, 8'hFF, 1'b1, 8'h80);
        send_cmd(OP_RECV_ACK, 8'h00, 1'b0, 8'h7F);
        // repeated start without a stop
        send_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_READ, 8'hFF, 1'b1, 8'h00);
        send_cmd(OP_READ, 8'h00, 1'b0, 8'hFF);
        send_cmd(OP_READ, 8'h00, 1'b0, 8'h5A);
        send_cmd(OP_SEND_ACK, 8'h00, 1'b0, 8'hFF);
        send_cmd(OP_SEND_ACK, 8'hFF, 1'b1, 8'h00);
        // unused codes between real commands
        send_cmd(3'd6, 8'hFF, 1'b1, 8'hFF);
        send_cmd(3'd7, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_STOP, 8'hFF, 1'b1, 8'hFF);
        send_cmd(3'd7, 8'h3C, 1'b1, 8'hC3);
    endtask

    task automatic test_zero_ticks();
        set_ticks(16'd0);
        send_cmd(OP_START, 8'h00, 1'b0, 8'h00);
        send_cmd(OP_READ, 8'h00, 1'b0, 8'hC3);
        send_cmd(OP_RECV_ACK, 8'h00, 1'b0, 8'h80);
        send_cmd(OP_STOP, 8'h00, 1'b0, 8'h00);
    endtask

    // receiver stalls long while commands keep coming, so push backs up on full
    task automatic test_backpressure();
        int k;
        set_ticks(16'd2);
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 12; k++)
            send_rand_fields(3'($urandom_range(5)));
        wait_idle();
    endtask

    task automatic test_random();
        logic [15:0] tick_set[5];
        logic [7:0]  addr;
        int          r;
        int          k;
        int          nbytes;
        int          round_start;
        tick_set = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd4};
        for (r = 0; r < 5; r++)
        begin
            set_ticks(tick_set[r]);
            no_idle <= (r == 0);
            round_start = cmds_sent;
            while (cmds_sent - round_start < RANDOM_CMDS / 5)
            begin
                if ($urandom_range(9) == 0)
                    send_rand_fields(3'($urandom_range(7)));
                else
                begin
                    addr = 8'($urandom);
                    send_rand_fields(OP_START);
                    send_cmd(OP_WRITE, addr, 1'($urandom), 8'($urandom));
                    send_rand_fields(OP_RECV_ACK);
                    nbytes = $urandom_range(1, 4);
                    for (k = 0; k < nbytes; k++)
                        if (addr[0])
                        begin
                            send_rand_fields(OP_READ);
                            send_rand_fields(OP_SEND_ACK);
                        end
                        else
                        begin
                            send_rand_fields(OP_WRITE);
                            send_rand_fields(OP_RECV_ACK);
                        end
                    // sometimes leave the bus held for a repeated start
                    if ($urandom_range(4) != 0)
                        send_rand_fields(OP_STOP);
                end
            end
        end
        no_idle <= 1'b0;
    endtask

    task automatic test_max_ticks();
        set_ticks(16'hFFFF);
        send_rand_fields(OP_STOP);
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_ticks();
        test_directed();
        test_zero_ticks();
        test_backpressure();
        test_random();
        test_max_ticks();
        $display("covered %0d bus commands over %0d phase timings, %0d phases checked",
                 cmds_sent, settings_used, phases_checked);
        $display("including bus stalls, unused codes and the widest phase hold");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d phases outstanding", phase_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
